### rtl/indexed_list_insert_remove_assert.svh
// Assertion macros for the checker file of the indexed list block.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ILIR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed list check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ILIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed list check failed");

`endif

### rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Action codes, status codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_POP    = 3'd2,
      ACT_REMOVE = 3'd3,
      ACT_READ   = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic signed [31:0] ERR_WORD = -32'sd1;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load;
   } cell_ctl_type;

endpackage

### rtl/ilir_cell.sv
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one list word and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ilir_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 6
) (
   input  logic                  clock,
   input  ilir_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]         pos,
   input  logic [IW-1:0]         sel,
   input  logic signed [31:0]    value,
   input  logic signed [31:0]    left_word,
   input  logic signed [31:0]    right_word,
   output logic signed [31:0]    word,
   output logic signed [31:0]    rd_word
);
   import ilir_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic signed [31:0] word_ff;
   logic signed [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.shift_up && (MY_IDX > pos)) begin
         word_in = left_word;
      end
      if ((ctl.shift_up || ctl.load) && (MY_IDX == pos)) begin
         word_in = value;
      end
      if (ctl.shift_down && (MY_IDX >= pos)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = (sel == MY_IDX) ? word_ff : '0;

endmodule

### rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and remove
// Ordered list of signed words in a row of cells, with a count of entries.
// ----------------------------------------------------------------------------
// Busy stays low, so a new item may be started
// in every cycle, and its result appears with strobe in the cycle after the
// item is accepted, for that one cycle only. The receiver cannot stall the
// block, so results must be taken as they come. All cells shift in parallel
// in the accept cycle, and a read or pop selects its word across the row of
// cells in that same cycle. The list needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               strobe,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_count
);
   import ilir_pkg::*;

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int CMP_W = (CW > 7) ? CW : 7;

   logic [CW-1:0]       cnt_ff;
   logic [CW-1:0]       cnt_in;
   logic                strobe_ff;
   logic signed [31:0]  read_value_ff;
   logic signed [31:0]  read_value_in;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;

   logic                accept;
   logic [CMP_W-1:0]    pos_c;
   logic [CMP_W-1:0]    cnt_c;
   logic                full;
   logic                use_read;
   cell_ctl_type        ctl;
   logic [IW-1:0]       cell_pos;
   logic [IW-1:0]       cell_sel;
   logic signed [31:0]  words [DEPTH];
   logic signed [31:0]  rd_words [DEPTH];
   logic signed [31:0]  rd_or;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pos_c  = CMP_W'(req_position);
   assign cnt_c  = CMP_W'(cnt_ff);
   assign full   = cnt_c >= CMP_W'(DEPTH);

   always_comb begin
      ctl       = '0;
      cell_pos  = IW'(req_position);
      cell_sel  = IW'(req_position);
      cnt_in    = cnt_ff;
      status_in = ST_OK;
      use_read  = 1'b0;
      case (action_type'(req_action))
         ACT_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.load = accept;
               cell_pos = IW'(cnt_ff);
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            if (pos_c > cnt_c) begin
               status_in = ST_BAD;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.shift_up = accept;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ACT_POP: begin
            if (cnt_ff == '0) begin
               status_in = ST_BAD;
            end else begin
               cell_sel = IW'(cnt_ff - 1'b1);
               use_read = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (pos_c >= cnt_c) begin
               status_in = ST_BAD;
            end else begin
               ctl.shift_down = accept;
               cnt_in         = cnt_ff - 1'b1;
            end
         end
         ACT_READ: begin
            if (pos_c >= cnt_c) begin
               status_in = ST_BAD;
            end else begin
               use_read = 1'b1;
            end
         end
         ACT_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [31:0] left_word;
         logic signed [31:0] right_word;
         if (gi == 0) begin : g_first
            assign left_word = '0;
         end else begin : g_left
            assign left_word = words[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_word = words[gi];
         end else begin : g_right
            assign right_word = words[gi+1];
         end
         ilir_cell #(
            .INDEX (gi),
            .IW    (IW)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (cell_pos),
            .sel        (cell_sel),
            .value      (req_value),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[gi]),
            .rd_word    (rd_words[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | rd_words[i];
      end
   end

   always_comb begin
      if (status_in != ST_OK) begin
         read_value_in = ERR_WORD;
      end else if (use_read) begin
         read_value_in = rd_or;
      end else begin
         read_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
      end
   end

   assign strobe         = strobe_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = 7'(cnt_ff);

endmodule

### rtl/ilir_checker.sv
// ----------------------------------------------------------------------------
// Indexed list checker
// Port-level checks on the result timing and on the result codes.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_assert.svh"

module ilir_checker #(
   parameter int DEPTH = 64
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_action,
   input logic [6:0]         req_position,
   input logic signed [31:0] req_value,
   input logic               strobe,
   input logic signed [31:0] rsp_read_value,
   input logic [1:0]         rsp_status,
   input logic [6:0]         rsp_count
);
   import ilir_pkg::*;

   logic accept;
   logic used_value;

   assign accept     = start && !busy;
   assign used_value = (req_position != 7'd0) || (req_value != 32'sd0) || 1'b1;

   `ILIR_ASSERT_NEXT(a_result_follows, accept, strobe)
   `ILIR_ASSERT_NEXT(a_no_spurious, !accept, !strobe)
   `ILIR_ASSERT_NOW(a_error_word, strobe && (rsp_status != ST_OK) && used_value, rsp_read_value == ERR_WORD)
   `ILIR_ASSERT_NOW(a_full_count, strobe && (rsp_status == ST_FULL), rsp_count == 7'(DEPTH))
   `ILIR_ASSERT_NOW(a_clear_empty, strobe && ($past(req_action) == ACT_CLEAR), rsp_count == 7'd0)

endmodule

bind indexed_list_insert_remove ilir_checker #(.DEPTH(DEPTH)) u_ilir_checker (.*);

### test/indexed_list_insert_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives directed and random push, insert, pop, remove, read, clear and unused
// code items into the list, mirrors the list contents in a local model, and
// compares every result against the model's expectation in order of issue.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;
   import ilir_pkg::*;

   localparam int DEPTH = 64;
   localparam logic [2:0] ACT_NOP_A = 3'd6;
   localparam logic [2:0] ACT_NOP_B = 3'd7;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         count;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_action = ACT_PUSH;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               strobe;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_count;

   logic signed [31:0] model_store [DEPTH];
   int                 model_count = 0;
   list_result_type    pending_results [$];

   bit idle_enable = 1'b1;
   int error_count = 0;
   int items_sent = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int action_hits [8];

   indexed_list_insert_remove #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_value      (req_value),
      .strobe         (strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_result_type list_model_step(input logic [2:0] act,
                                                       input logic [6:0] pos,
                                                       input logic signed [31:0] word);
      list_result_type r;
      int i;
      r.read_value = '0;
      r.status = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (model_count >= DEPTH) begin
               r.status = ST_FULL;
               r.read_value = ERR_WORD;
            end else begin
               model_store[model_count] = word;
               model_count++;
            end
         end
         ACT_INSERT: begin
            if (int'(pos) > model_count) begin
               r.status = ST_BAD;
               r.read_value = ERR_WORD;
            end else if (model_count >= DEPTH) begin
               r.status = ST_FULL;
               r.read_value = ERR_WORD;
            end else begin
               for (i = model_count; i > int'(pos); i--) model_store[i] = model_store[i - 1];
               model_store[pos] = word;
               model_count++;
            end
         end
         ACT_POP: begin
            if (model_count == 0) begin
               r.status = ST_BAD;
               r.read_value = ERR_WORD;
            end else begin
               model_count--;
               r.read_value = model_store[model_count];
            end
         end
         ACT_REMOVE: begin
            if (int'(pos) >= model_count) begin
               r.status = ST_BAD;
               r.read_value = ERR_WORD;
            end else begin
               for (i = int'(pos); i + 1 < model_count; i++) model_store[i] = model_store[i + 1];
               model_count--;
            end
         end
         ACT_READ: begin
            if (int'(pos) >= model_count) begin
               r.status = ST_BAD;
               r.read_value = ERR_WORD;
            end else begin
               r.read_value = model_store[pos];
            end
         end
         ACT_CLEAR: begin
            model_count = 0;
         end
         default: begin
         end
      endcase
      r.count = model_count[6:0];
      return r;
   endfunction

   task automatic send_item(input logic [2:0] act, input logic [6:0] pos,
                            input logic signed [31:0] word);
      list_result_type exp_res;
      int gap;
      start <= 1'b1;
      req_action <= act;
      req_position <= pos;
      req_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
      exp_res = list_model_step(act, pos, word);
      pending_results.push_back(exp_res);
      items_sent++;
      action_hits[act]++;
      if (exp_res.status == ST_FULL) full_hits++;
      if (exp_res.count == 0) empty_hits++;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_item(input bit grow);
      int r;
      logic [2:0] act;
      logic [6:0] pos;
      r = $urandom_range(0, 99);
      if (grow)
         act = (r < 30) ? ACT_PUSH : (r < 55) ? ACT_INSERT : (r < 65) ? ACT_POP :
               (r < 75) ? ACT_REMOVE : (r < 95) ? ACT_READ : (r < 97) ? ACT_CLEAR :
               ($urandom_range(0, 1) ? ACT_NOP_B : ACT_NOP_A);
      else
         act = (r < 10) ? ACT_PUSH : (r < 20) ? ACT_INSERT : (r < 45) ? ACT_POP :
               (r < 70) ? ACT_REMOVE : (r < 95) ? ACT_READ : (r < 97) ? ACT_CLEAR :
               ($urandom_range(0, 1) ? ACT_NOP_B : ACT_NOP_A);
      if ($urandom_range(0, 4) == 0)
         pos = 7'($urandom_range(0, 127));
      else if (act == ACT_INSERT)
         pos = 7'($urandom_range(0, model_count));
      else if (act == ACT_REMOVE || act == ACT_READ)
         pos = (model_count == 0) ? 7'd0 : 7'($urandom_range(0, model_count - 1));
      else
         pos = 7'($urandom_range(0, 127));
      send_item(act, pos, $urandom);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic test_directed_cases();
      send_item(ACT_PUSH, 7'd0, 32'sh7FFFFFFF);
      send_item(ACT_PUSH, 7'd0, 32'sh80000000);
      send_item(ACT_PUSH, 7'd0, 32'sh00000000);
      send_item(ACT_PUSH, 7'd0, -32'sd1);
      send_item(ACT_READ, 7'd0, 32'sd0);
      send_item(ACT_READ, 7'd3, 32'sd0);
      send_item(ACT_READ, 7'd4, 32'sd0);
      send_item(ACT_INSERT, 7'd0, 32'sh5A5A5A5A);
      send_item(ACT_INSERT, 7'd5, 32'sh2C3D4E5F);
      send_item(ACT_INSERT, 7'd7, 32'sh11111111);
      send_item(ACT_INSERT, 7'd127, 32'sh22222222);
      send_item(ACT_REMOVE, 7'd0, 32'sd0);
      send_item(ACT_REMOVE, 7'd4, 32'sd0);
      send_item(ACT_REMOVE, 7'd4, 32'sd0);
      send_item(ACT_REMOVE, 7'd127, 32'sd0);
      send_item(ACT_READ, 7'd2, 32'sd0);
      repeat (4) send_item(ACT_POP, 7'd0, 32'sd0);
      send_item(ACT_POP, 7'd0, 32'sd0);
      send_item(ACT_REMOVE, 7'd0, 32'sd0);
      send_item(ACT_READ, 7'd0, 32'sd0);
      send_item(ACT_INSERT, 7'd0, 32'sh0F0F0F0F);
      send_item(ACT_CLEAR, 7'd0, 32'sd0);
      send_item(ACT_CLEAR, 7'd0, 32'sd0);
      send_item(ACT_NOP_A, 7'd0, 32'sd0);
      send_item(ACT_NOP_B, 7'd0, 32'sd0);
   endtask

   task automatic test_full_list();
      send_item(ACT_CLEAR, 7'd0, 32'sd0);
      repeat (DEPTH) send_item(ACT_PUSH, 7'($urandom_range(0, 127)), $urandom);
      send_item(ACT_PUSH, 7'd0, 32'sh12345678);
      send_item(ACT_INSERT, 7'd0, 32'sh12345678);
      send_item(ACT_INSERT, 7'(DEPTH), 32'sh12345678);
      send_item(ACT_INSERT, 7'(DEPTH + 1), 32'sh12345678);
      send_item(ACT_READ, 7'(DEPTH - 1), 32'sd0);
      send_item(ACT_READ, 7'(DEPTH), 32'sd0);
      send_item(ACT_REMOVE, 7'(DEPTH - 1), 32'sd0);
      send_item(ACT_INSERT, 7'd10, $urandom);
      send_item(ACT_INSERT, 7'd0, $urandom);
      repeat (5) send_item(ACT_REMOVE, 7'd0, 32'sd0);
      repeat (8) send_item(ACT_READ, 7'($urandom_range(0, model_count - 1)), 32'sd0);
      send_item(ACT_POP, 7'd0, 32'sd0);
   endtask

   task automatic test_pause_until_drained();
      repeat (6) send_random_item(1'b1);
      wait_drained();
      repeat (3) @(posedge clock);
      repeat (6) send_random_item(1'b0);
      wait_drained();
   endtask

   task automatic test_random_mix();
      int run_len;
      bit grow;
      int total;
      total = 0;
      while (total < 1300) begin
         grow = $urandom_range(0, 1);
         run_len = $urandom_range(60, 140);
         repeat (run_len) send_random_item(grow);
         total += run_len;
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (60) send_random_item(1'b1);
      repeat (60) send_random_item(1'b0);
   endtask

   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("Unexpected result: value %0d status %0d count %0d",
                        rsp_read_value, rsp_status, rsp_count);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_read_value !== exp_res.read_value || rsp_status !== exp_res.status ||
                rsp_count !== exp_res.count) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Mismatch: expected value %0d status %0d count %0d, got %0d %0d %0d",
                           exp_res.read_value, exp_res.status, exp_res.count,
                           rsp_read_value, rsp_status, rsp_count);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_list();
      test_pause_until_drained();
      test_random_mix();
      test_back_to_back();
      wait_drained();
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count += pending_results.size();
         $display("%0d expected results never arrived.", pending_results.size());
      end
      $display("Covered %0d items: %0d push, %0d insert, %0d pop, %0d remove,",
               items_sent, action_hits[ACT_PUSH], action_hits[ACT_INSERT],
               action_hits[ACT_POP], action_hits[ACT_REMOVE]);
      $display("%0d read, %0d clear, %0d unused codes.",
               action_hits[ACT_READ], action_hits[ACT_CLEAR],
               action_hits[ACT_NOP_A] + action_hits[ACT_NOP_B]);
      $display("List refused %0d items as full and ended %0d items empty; %0d errors.",
               full_hits, empty_hits, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/indexed_list_insert_remove.sv
rtl/ilir_checker.sv
test/indexed_list_insert_remove_tb.sv
